// ----- sv/scba_pkg.sv -----
`timescale 1ns / 1ps
// Package for the size-class block allocator: sizes, codes, per-class row type
// and the reset/provisioning helper functions. No dependencies.
package scba_pkg;

	localparam int NUM_CLASSES    = 16;
	localparam int INIT_CLASSES   = 8;
	localparam int CHUNK_BLOCKS   = 8;
	localparam int CLASS_CAPACITY = 64;
	localparam int GRAIN          = 8;

	localparam int CLS_W  = $clog2(NUM_CLASSES);
	localparam int SLOT_W = $clog2(CLASS_CAPACITY);
	localparam int HDL_W  = 10;
	localparam int CNT_W  = $clog2(CLASS_CAPACITY + 1);
	localparam int SIZE_W = 12;
	localparam int BYTE_W = 8;
	localparam int ACC_W  = 17;

	typedef logic [CLS_W-1:0]  cls_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [BYTE_W-1:0] blk_bytes_t;
	typedef logic [ACC_W-1:0]  acc_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_ZERO     = 3'd1,
		STAT_BIG      = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_NOTALLOC = 3'd4,
		STAT_IGNORED  = 3'd5
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_POP
	} state_t;

	typedef struct packed {
		logic [CLASS_CAPACITY-1:0] in_use;
		cnt_t                      prov;
		cnt_t                      fresh;
		cnt_t                      ret;
	} cls_row_t;

	function automatic cnt_t chunk_for(cnt_t prov);
		cnt_t room;
		room = (prov < cnt_t'(CLASS_CAPACITY)) ? cnt_t'(CLASS_CAPACITY) - prov : '0;
		return (cnt_t'(CHUNK_BLOCKS) < room) ? cnt_t'(CHUNK_BLOCKS) : room;
	endfunction

	function automatic blk_bytes_t class_bytes(cls_t c);
		return blk_bytes_t'({(5'(c) + 5'd1), 3'b000});
	endfunction

	function automatic cls_row_t cls_reset(cls_t c);
		cls_row_t r;
		r        = '0;
		r.prov   = (int'(c) < INIT_CLASSES) ? chunk_for('0) : '0;
		return r;
	endfunction

	function automatic acc_t init_bytes();
		acc_t s;
		s = '0;
		for (int c = 0; c < NUM_CLASSES && c < INIT_CLASSES; c++) begin
			s = s + acc_t'(chunk_for('0)) * acc_t'((c + 1) * GRAIN);
		end
		return s;
	endfunction

	localparam acc_t INIT_BYTES = init_bytes();

endpackage

// ----- sv/size_class_block_allocator.sv -----
`timescale 1ns / 1ps
// Size-class block allocator top level: class-row memory, returned-slot stack
// memory, request sequencer and byte counters. Depends on scba_pkg.
//
// A request is taken when start is high and busy is low. Its word comes back on
// the result ports with done high for one cycle, after a read-modify-write of
// the class row memory: the row is read on acceptance and written in ST_LOOK,
// or, when an alloc pops a previously freed slot, the slot stack memory is read
// in ST_LOOK and the row written in ST_POP. Busy stays high until done and a new
// request may be taken in the cycle done is high. The receiver cannot stall:
// each result must be taken in its done cycle.
module size_class_block_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             req_type,
	input  logic [scba_pkg::SIZE_W-1:0]      req_size,
	input  logic [scba_pkg::HDL_W-1:0]       req_handle,
	output logic                             done,
	output logic [2:0]                       status,
	output logic [scba_pkg::HDL_W-1:0]       granted_handle,
	output logic [scba_pkg::BYTE_W-1:0]      granted_bytes,
	output logic [scba_pkg::ACC_W-1:0]       free_bytes,
	output logic [scba_pkg::ACC_W-1:0]       active_bytes,
	output logic [scba_pkg::ACC_W-1:0]       total_bytes
);

	scba_pkg::state_t state_q, state_d;

	scba_pkg::cls_row_t cls_mem [scba_pkg::NUM_CLASSES];
	scba_pkg::slot_t    stk_mem [scba_pkg::NUM_CLASSES * scba_pkg::CLASS_CAPACITY];

	logic [scba_pkg::NUM_CLASSES-1:0] row_vld_q;

	scba_pkg::cls_row_t cls_rd_q;
	scba_pkg::slot_t    stk_rd_q;

	// request registers
	logic                         type_s1;
	logic                         zero_s1;
	logic                         big_s1;
	logic                         rowv_s1;
	scba_pkg::cls_t               cls_s1;
	scba_pkg::slot_t              slot_s1;

	scba_pkg::acc_t free_q, active_q, total_q;
	scba_pkg::acc_t free_d, active_d, total_d;

	logic                          done_q;
	scba_pkg::status_t             status_q, res_status;
	logic [scba_pkg::HDL_W-1:0]    handle_q, res_handle;
	scba_pkg::blk_bytes_t          gbytes_q, res_bytes;
	logic                          fin;

	logic                          accept;
	logic [scba_pkg::SIZE_W-1:0]   sz_m1;
	scba_pkg::cls_t                cls_in;

	scba_pkg::cls_row_t   row_eff, row_wd;
	logic                 row_we;
	logic                 stk_we, stk_re;
	logic [scba_pkg::HDL_W-1:0] stk_wa, stk_ra;
	scba_pkg::slot_t      stk_wd;

	scba_pkg::blk_bytes_t bytes;
	scba_pkg::cnt_t       grow_n;
	logic                 grow;
	logic                 pop_take;
	scba_pkg::slot_t      slot_new;

	assign accept = start && (state_q == scba_pkg::ST_IDLE);
	assign busy   = (state_q != scba_pkg::ST_IDLE);
	assign sz_m1  = req_size - scba_pkg::SIZE_W'(1);
	assign cls_in = (req_type == scba_pkg::REQ_FREE) ?
		req_handle[scba_pkg::HDL_W-1 -: scba_pkg::CLS_W] : sz_m1[3 +: scba_pkg::CLS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= scba_pkg::ST_IDLE;
			row_vld_q <= '0;
			free_q    <= scba_pkg::INIT_BYTES;
			active_q  <= '0;
			total_q   <= scba_pkg::INIT_BYTES;
			done_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			free_q   <= free_d;
			active_q <= active_d;
			total_q  <= total_d;
			done_q   <= fin;
			if (row_we) begin
				row_vld_q[cls_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1  <= req_type;
			zero_s1  <= (req_size == '0);
			big_s1   <= (32'(sz_m1 >> 3) >= 32'(scba_pkg::NUM_CLASSES));
			cls_s1   <= cls_in;
			slot_s1  <= req_handle[scba_pkg::SLOT_W-1:0];
			rowv_s1  <= row_vld_q[cls_in];
			cls_rd_q <= cls_mem[cls_in];
		end
		if (row_we) begin
			cls_mem[cls_s1] <= row_wd;
		end
		if (stk_re) begin
			stk_rd_q <= stk_mem[stk_ra];
		end
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (fin) begin
			status_q <= res_status;
			handle_q <= res_handle;
			gbytes_q <= res_bytes;
		end
	end

	assign row_eff  = rowv_s1 ? cls_rd_q : scba_pkg::cls_reset(cls_s1);
	assign bytes    = scba_pkg::class_bytes(cls_s1);
	assign grow_n   = scba_pkg::chunk_for(row_eff.prov);
	assign grow     = (row_eff.ret == '0) && (row_eff.fresh >= row_eff.prov);
	assign pop_take = (type_s1 == scba_pkg::REQ_ALLOC) && !zero_s1 && !big_s1 &&
		(row_eff.ret != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scba_pkg::ST_IDLE: if (start) state_d = scba_pkg::ST_LOOK;
			scba_pkg::ST_LOOK: state_d = pop_take ? scba_pkg::ST_POP : scba_pkg::ST_IDLE;
			scba_pkg::ST_POP:  state_d = scba_pkg::ST_IDLE;
			default:           state_d = scba_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		fin        = 1'b0;
		res_status = scba_pkg::STAT_OK;
		res_handle = '0;
		res_bytes  = '0;
		row_we     = 1'b0;
		row_wd     = row_eff;
		stk_we     = 1'b0;
		stk_wa     = {cls_s1, row_eff.ret[scba_pkg::SLOT_W-1:0]};
		stk_wd     = slot_s1;
		stk_re     = 1'b0;
		stk_ra     = {cls_s1, scba_pkg::SLOT_W'(row_eff.ret - scba_pkg::cnt_t'(1))};
		slot_new   = row_eff.fresh[scba_pkg::SLOT_W-1:0];
		free_d     = free_q;
		active_d   = active_q;
		total_d    = total_q;
		unique case (state_q)
			scba_pkg::ST_IDLE: begin
			end
			scba_pkg::ST_LOOK: begin
				if (type_s1 == scba_pkg::REQ_ALLOC) begin
					if (zero_s1) begin
						fin        = 1'b1;
						res_status = scba_pkg::STAT_ZERO;
					end else if (big_s1) begin
						fin        = 1'b1;
						res_status = scba_pkg::STAT_BIG;
					end else if (grow && grow_n == '0) begin
						fin        = 1'b1;
						res_status = scba_pkg::STAT_FULL;
					end else if (pop_take) begin
						stk_re = 1'b1;
					end else begin
						fin                    = 1'b1;
						res_handle             = {cls_s1, slot_new};
						res_bytes              = bytes;
						row_we                 = 1'b1;
						row_wd.in_use[slot_new] = 1'b1;
						row_wd.fresh           = row_eff.fresh + scba_pkg::cnt_t'(1);
						row_wd.prov            = row_eff.prov + (grow ? grow_n : '0);
						free_d   = free_q + scba_pkg::acc_t'(grow ? grow_n : '0) *
							scba_pkg::acc_t'(bytes) - scba_pkg::acc_t'(bytes);
						total_d  = total_q + scba_pkg::acc_t'(grow ? grow_n : '0) *
							scba_pkg::acc_t'(bytes);
						active_d = active_q + scba_pkg::acc_t'(bytes);
					end
				end else begin
					if (zero_s1) begin
						fin        = 1'b1;
						res_status = scba_pkg::STAT_IGNORED;
					end else if (!row_eff.in_use[slot_s1]) begin
						fin        = 1'b1;
						res_status = scba_pkg::STAT_NOTALLOC;
					end else begin
						fin                    = 1'b1;
						res_bytes              = bytes;
						row_we                 = 1'b1;
						row_wd.in_use[slot_s1] = 1'b0;
						if (row_eff.ret < scba_pkg::cnt_t'(scba_pkg::CLASS_CAPACITY)) begin
							row_wd.ret = row_eff.ret + scba_pkg::cnt_t'(1);
						end
						stk_we   = 1'b1;
						free_d   = free_q + scba_pkg::acc_t'(bytes);
						active_d = active_q - scba_pkg::acc_t'(bytes);
					end
				end
			end
			scba_pkg::ST_POP: begin
				fin                     = 1'b1;
				res_handle              = {cls_s1, stk_rd_q};
				res_bytes               = bytes;
				row_we                  = 1'b1;
				row_wd.in_use[stk_rd_q] = 1'b1;
				row_wd.ret              = row_eff.ret - scba_pkg::cnt_t'(1);
				free_d   = free_q - scba_pkg::acc_t'(bytes);
				active_d = active_q + scba_pkg::acc_t'(bytes);
			end
			default: begin
			end
		endcase
	end

	assign done           = done_q;
	assign status         = status_q;
	assign granted_handle = handle_q;
	assign granted_bytes  = gbytes_q;
	assign free_bytes     = free_q;
	assign active_bytes   = active_q;
	assign total_bytes    = total_q;

`ifndef SYNTHESIS
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == scba_pkg::ST_LOOK || $past(state_q) == scba_pkg::ST_POP))
		else $error("result strobe without a request in flight");
	a_bytes_balance: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (18'(free_bytes) + 18'(active_bytes) == 18'(total_bytes)))
		else $error("free plus active bytes differ from total");
	a_handle_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != scba_pkg::STAT_OK) |-> (granted_handle == '0 && granted_bytes == '0))
		else $error("error word carries a handle or size");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == scba_pkg::ST_POP) |=> (state_q == scba_pkg::ST_IDLE && done))
		else $error("pop did not complete in one cycle");
`endif

endmodule

// ----- tb/sv/scba_result_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the size-class block allocator: keeps its own allocator
// state, predicts the word of each accepted request and compares done words.
// Depends on scba_pkg.
module scba_result_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic                        req_type,
	input  logic [scba_pkg::SIZE_W-1:0] req_size,
	input  logic [scba_pkg::HDL_W-1:0]  req_handle,
	input  logic                        done,
	input  logic [2:0]                  status,
	input  logic [scba_pkg::HDL_W-1:0]  granted_handle,
	input  logic [scba_pkg::BYTE_W-1:0] granted_bytes,
	input  logic [scba_pkg::ACC_W-1:0]  free_bytes,
	input  logic [scba_pkg::ACC_W-1:0]  active_bytes,
	input  logic [scba_pkg::ACC_W-1:0]  total_bytes,
	output int                          errors,
	output int                          words_waiting,
	output int                          words_checked,
	output int                          full_seen,
	output int                          bad_frees_seen
);

	typedef struct packed {
		scba_pkg::status_t          st;
		logic [scba_pkg::HDL_W-1:0] handle;
		scba_pkg::blk_bytes_t       bytes;
		scba_pkg::acc_t             free_b;
		scba_pkg::acc_t             active_b;
		scba_pkg::acc_t             total_b;
	} alloc_word_t;

	alloc_word_t expected_words[$];
	alloc_word_t want;

	int freed_slots[scba_pkg::NUM_CLASSES][scba_pkg::CLASS_CAPACITY];
	int freed_depth[scba_pkg::NUM_CLASSES];
	int fresh_next[scba_pkg::NUM_CLASSES];
	int prov_blocks[scba_pkg::NUM_CLASSES];
	bit block_taken[scba_pkg::NUM_CLASSES*scba_pkg::CLASS_CAPACITY];
	int free_total;
	int active_total;
	int prov_total;

	function automatic void serve_request(scba_pkg::req_t kind,
			logic [scba_pkg::SIZE_W-1:0] size, logic [scba_pkg::HDL_W-1:0] hdl);
		alloc_word_t w;
		int c, bytes, slot, grow;
		w = '0;
		w.st = scba_pkg::STAT_OK;
		if (kind == scba_pkg::REQ_ALLOC) begin
			c = (int'(size) + scba_pkg::GRAIN - 1) / scba_pkg::GRAIN - 1;
			if (size == 0)
				w.st = scba_pkg::STAT_ZERO;
			else if (c >= scba_pkg::NUM_CLASSES)
				w.st = scba_pkg::STAT_BIG;
			else begin
				bytes = (c + 1) * scba_pkg::GRAIN;
				grow = 0;
				if (freed_depth[c] == 0 && fresh_next[c] >= prov_blocks[c]) begin
					grow = scba_pkg::CLASS_CAPACITY - prov_blocks[c];
					if (grow < 0)
						grow = 0;
					if (grow > scba_pkg::CHUNK_BLOCKS)
						grow = scba_pkg::CHUNK_BLOCKS;
					if (grow == 0)
						w.st = scba_pkg::STAT_FULL;
				end
				if (w.st == scba_pkg::STAT_OK) begin
					prov_blocks[c] += grow;
					free_total += grow * bytes;
					prov_total += grow * bytes;
					if (freed_depth[c] > 0) begin
						freed_depth[c]--;
						slot = freed_slots[c][freed_depth[c]];
					end else begin
						slot = fresh_next[c] % scba_pkg::CLASS_CAPACITY;
						fresh_next[c]++;
					end
					block_taken[c*scba_pkg::CLASS_CAPACITY + slot] = 1'b1;
					free_total -= bytes;
					active_total += bytes;
					w.handle = scba_pkg::HDL_W'(c*scba_pkg::CLASS_CAPACITY + slot);
					w.bytes = scba_pkg::BYTE_W'(bytes);
				end
			end
		end else begin
			c = int'(hdl) / scba_pkg::CLASS_CAPACITY;
			if (size == 0)
				w.st = scba_pkg::STAT_IGNORED;
			else if (c >= scba_pkg::NUM_CLASSES || !block_taken[hdl])
				w.st = scba_pkg::STAT_NOTALLOC;
			else begin
				bytes = (c + 1) * scba_pkg::GRAIN;
				block_taken[hdl] = 1'b0;
				freed_slots[c][freed_depth[c] % scba_pkg::CLASS_CAPACITY] =
					int'(hdl) % scba_pkg::CLASS_CAPACITY;
				if (freed_depth[c] < scba_pkg::CLASS_CAPACITY)
					freed_depth[c]++;
				free_total += bytes;
				active_total -= bytes;
				w.bytes = scba_pkg::BYTE_W'(bytes);
			end
		end
		w.free_b = scba_pkg::ACC_W'(free_total);
		w.active_b = scba_pkg::ACC_W'(active_total);
		w.total_b = scba_pkg::ACC_W'(prov_total);
		expected_words.push_back(w);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			free_total = 0;
			active_total = 0;
			for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
				freed_depth[c] = 0;
				fresh_next[c] = 0;
				prov_blocks[c] = 0;
				if (c < scba_pkg::INIT_CLASSES)
					prov_blocks[c] = (scba_pkg::CHUNK_BLOCKS < scba_pkg::CLASS_CAPACITY) ?
						scba_pkg::CHUNK_BLOCKS : scba_pkg::CLASS_CAPACITY;
				free_total += prov_blocks[c] * (c + 1) * scba_pkg::GRAIN;
				for (int s = 0; s < scba_pkg::CLASS_CAPACITY; s++)
					block_taken[c*scba_pkg::CLASS_CAPACITY + s] = 1'b0;
			end
			prov_total = free_total;
			errors = 0;
			words_checked = 0;
			full_seen = 0;
			bad_frees_seen = 0;
			words_waiting <= 0;
		end else begin
			// compare before taking the new request: done may coincide with acceptance
			if (done) begin
				if (expected_words.size() == 0) begin
					if (errors < 10)
						$display("unexpected word at %0t: st=%0d h=%0d b=%0d", $realtime,
							status, granted_handle, granted_bytes);
					errors++;
				end else begin
					want = expected_words.pop_front();
					words_checked++;
					if (want.st == scba_pkg::STAT_FULL)
						full_seen++;
					if (want.st == scba_pkg::STAT_NOTALLOC)
						bad_frees_seen++;
					if (status !== want.st || granted_handle !== want.handle ||
							granted_bytes !== want.bytes || free_bytes !== want.free_b ||
							active_bytes !== want.active_b || total_bytes !== want.total_b) begin
						if (errors < 10) begin
							$display("mismatch on word %0d: exp st=%0d h=%0d b=%0d free=%0d act=%0d tot=%0d",
								words_checked, want.st, want.handle, want.bytes, want.free_b,
								want.active_b, want.total_b);
							$display("  got st=%0d h=%0d b=%0d free=%0d act=%0d tot=%0d",
								status, granted_handle, granted_bytes, free_bytes,
								active_bytes, total_bytes);
						end
						errors++;
					end
				end
			end
			if (start && !busy)
				serve_request(scba_pkg::req_t'(req_type), req_size, req_handle);
			words_waiting <= expected_words.size();
		end
	end

endmodule

// ----- tb/sv/size_class_block_allocator_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the size-class block allocator: clock, reset, request
// stimulus and verdict. Depends on scba_pkg, the allocator and scba_result_checker.
module size_class_block_allocator_tb;

	localparam int ITEMS       = 1220;
	localparam int CYCLE_LIMIT = 400000;

	logic                        clk        = 1'b0;
	logic                        arst_n     = 1'b0;
	logic                        start      = 1'b0;
	logic                        req_type   = 1'b0;
	logic [scba_pkg::SIZE_W-1:0] req_size   = '0;
	logic [scba_pkg::HDL_W-1:0]  req_handle = '0;
	logic                        busy;
	logic                        done;
	logic [2:0]                  status;
	logic [scba_pkg::HDL_W-1:0]  granted_handle;
	logic [scba_pkg::BYTE_W-1:0] granted_bytes;
	logic [scba_pkg::ACC_W-1:0]  free_bytes;
	logic [scba_pkg::ACC_W-1:0]  active_bytes;
	logic [scba_pkg::ACC_W-1:0]  total_bytes;

	int errors, words_waiting, words_checked, full_seen, bad_frees_seen;
	int cycle_cnt   = 0;
	int sent        = 0;
	int allocs_sent = 0;
	int frees_sent  = 0;
	int calm_left   = 0;

	logic [scba_pkg::HDL_W-1:0] live_handles[$];
	scba_pkg::req_t             kinds_in_flight[$];
	scba_pkg::req_t             done_kind;

	size_class_block_allocator i_dut (.*);
	scba_result_checker i_checker (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// handles granted by the block, kept only to steer frees toward live blocks
	always @(posedge clk) begin
		if (arst_n) begin
			if (done && kinds_in_flight.size() > 0) begin
				done_kind = kinds_in_flight.pop_front();
				if (done_kind == scba_pkg::REQ_ALLOC && status == scba_pkg::STAT_OK)
					live_handles.push_back(granted_handle);
			end
			if (start && !busy)
				kinds_in_flight.push_back(scba_pkg::req_t'(req_type));
		end
	end

	task automatic issue(scba_pkg::req_t kind, int size, int hdl);
		int r, gap;
		req_type <= kind;
		req_size <= scba_pkg::SIZE_W'(size);
		req_handle <= scba_pkg::HDL_W'(hdl);
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sent++;
		if (kind == scba_pkg::REQ_ALLOC)
			allocs_sent++;
		else
			frees_sent++;
		gap = 0;
		r = $urandom_range(0, 99);
		if (calm_left > 0)
			calm_left--;
		else if (r < 3)
			calm_left = 40;
		else if (r >= 50 && r < 85)
			gap = $urandom_range(1, 3);
		else if (r >= 85 && r < 97)
			gap = $urandom_range(4, 12);
		else if (r >= 97)
			gap = $urandom_range(20, 40);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic free_live();
		int idx;
		logic [scba_pkg::HDL_W-1:0] h;
		if (live_handles.size() == 0) begin
			issue(scba_pkg::REQ_FREE, $urandom_range(1, 4095), $urandom_range(0, 1023));
		end else begin
			idx = $urandom_range(0, live_handles.size() - 1);
			h = live_handles[idx];
			live_handles.delete(idx);
			issue(scba_pkg::REQ_FREE, $urandom_range(1, 4095), h);
		end
	endtask

	initial begin
		int r, c, len;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(scba_pkg::REQ_ALLOC, 0, 0);
		issue(scba_pkg::REQ_ALLOC, 4095, 1023);
		issue(scba_pkg::REQ_ALLOC, 129, 0);
		issue(scba_pkg::REQ_ALLOC, 2048, 0);
		issue(scba_pkg::REQ_ALLOC, 128, 0);
		issue(scba_pkg::REQ_ALLOC, 121, 0);
		issue(scba_pkg::REQ_ALLOC, 1, 0);
		issue(scba_pkg::REQ_ALLOC, 8, 0);
		issue(scba_pkg::REQ_ALLOC, 9, 0);
		issue(scba_pkg::REQ_FREE, 0, 1023);
		issue(scba_pkg::REQ_FREE, 1, 1023);
		issue(scba_pkg::REQ_FREE, 4095, 0);
		issue(scba_pkg::REQ_FREE, 7, 0);
		issue(scba_pkg::REQ_ALLOC, 5, 0);
		issue(scba_pkg::REQ_FREE, 1, 960);
		issue(scba_pkg::REQ_FREE, 2, 961);
		issue(scba_pkg::REQ_ALLOC, 127, 0);
		issue(scba_pkg::REQ_FREE, 0, 64);
		issue(scba_pkg::REQ_FREE, 3, 64);
		issue(scba_pkg::REQ_ALLOC, 16, 0);
		live_handles.delete();

		while (sent < ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 15) begin
				// fill one class, sometimes past its capacity
				c = $urandom_range(0, scba_pkg::NUM_CLASSES - 1);
				len = $urandom_range(1, 70);
				repeat (len) issue(scba_pkg::REQ_ALLOC,
					c*scba_pkg::GRAIN + $urandom_range(1, scba_pkg::GRAIN),
					$urandom_range(0, 1023));
			end else if (r < 30) begin
				len = $urandom_range(1, 40);
				repeat (len) free_live();
			end else begin
				r = $urandom_range(0, 99);
				if (r < 47)
					issue(scba_pkg::REQ_ALLOC, $urandom_range(1, 128), $urandom_range(0, 1023));
				else if (r < 50)
					issue(scba_pkg::REQ_ALLOC, 0, $urandom_range(0, 1023));
				else if (r < 55)
					issue(scba_pkg::REQ_ALLOC, $urandom_range(129, 4095),
						$urandom_range(0, 1023));
				else if (r < 85)
					free_live();
				else if (r < 93)
					issue(scba_pkg::REQ_FREE, $urandom_range(1, 4095), $urandom_range(0, 1023));
				else
					issue(scba_pkg::REQ_FREE, 0, $urandom_range(0, 1023));
			end
		end
		start <= 1'b0;
		@(posedge clk);
		while (words_waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d requests (%0d allocs, %0d frees), %0d result words checked.",
			sent, allocs_sent, frees_sent, words_checked);
		$display("Saw %0d class-full refusals and %0d rejected frees; %0d mismatches.",
			full_seen, bad_frees_seen, errors);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
